>>> sv/assert_macros.svh
// assertion helpers for the rms box downsampler
// each check is clocked on the rising edge and held off while reset is low
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH

`define ASSERT_ALWAYS(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

`define ASSERT_NEVER(label, clk, rst_n, cond, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

`else

`define ASSERT_ALWAYS(label, clk, rst_n, prop, msg)

`define ASSERT_NEVER(label, clk, rst_n, cond, msg)

`endif

`endif

>>> sv/rbd_pkg.sv
// ----------------------------------------------------------------------------
// rbd_pkg
// shared widths and the control bundle of the rms box downsampler
// ----------------------------------------------------------------------------
package rbd_pkg;

  localparam int unsigned ByteW     = 8;
  localparam int unsigned PixW      = 32;
  localparam int unsigned PixPerRow = 4;
  localparam int unsigned PixIdxW   = 2;
  localparam int unsigned NumCh     = 3;
  localparam int unsigned ChW       = 2;
  localparam int unsigned SqSumW    = 20;
  localparam int unsigned AlphaW    = 12;
  localparam int unsigned RootW     = SqSumW / 2;
  localparam int unsigned RemW      = RootW + 2;
  localparam int unsigned StepW     = 4;

  // one accumulate request per cycle
  typedef struct packed {
    logic             clear;
    logic             sq_add;
    logic [ChW-1:0]   ch;
    logic [ByteW-1:0] sq_byte;
    logic             alpha_add;
    logic [ByteW-1:0] alpha_byte;
  } rbd_acc_ctrl_t;

endpackage

>>> sv/rbd_accum.sv
// ----------------------------------------------------------------------------
// rbd_accum
// square and accumulate unit: one 8x8 squarer shared by the three color sums
// ----------------------------------------------------------------------------
module rbd_accum (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  rbd_pkg::rbd_acc_ctrl_t       ctrl_i,
  input  logic [rbd_pkg::ChW-1:0]      sel_i,
  output logic [rbd_pkg::SqSumW-1:0]   sum_o,
  output logic [rbd_pkg::AlphaW-1:0]   alpha_o
);
  import rbd_pkg::*;

  logic [SqSumW-1:0]  sq_q [NumCh];
  logic [SqSumW-1:0]  sq_d [NumCh];
  logic [AlphaW-1:0]  alpha_q, alpha_d;
  logic [2*ByteW-1:0] square;

  assign square = ctrl_i.sq_byte * ctrl_i.sq_byte;

  always_comb begin
    for (int i = 0; i < NumCh; i++) begin
      sq_d[i] = sq_q[i];
    end
    alpha_d = alpha_q;
    if (ctrl_i.clear) begin
      for (int i = 0; i < NumCh; i++) begin
        sq_d[i] = '0;
      end
      alpha_d = '0;
    end else begin
      if (ctrl_i.sq_add && (ctrl_i.ch < ChW'(NumCh))) begin
        sq_d[ctrl_i.ch] = sq_q[ctrl_i.ch] + SqSumW'(square);
      end
      if (ctrl_i.alpha_add) begin
        alpha_d = alpha_q + AlphaW'(ctrl_i.alpha_byte);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NumCh; i++) begin
        sq_q[i] <= '0;
      end
      alpha_q <= '0;
    end else begin
      for (int i = 0; i < NumCh; i++) begin
        sq_q[i] <= sq_d[i];
      end
      alpha_q <= alpha_d;
    end
  end

  assign sum_o   = (sel_i < ChW'(NumCh)) ? sq_q[sel_i] : '0;
  assign alpha_o = alpha_q;

endmodule

>>> sv/rbd_isqrt.sv
// ----------------------------------------------------------------------------
// rbd_isqrt
// iterative integer square root, one root bit per cycle, with remainder
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module rbd_isqrt (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        start_i,
  input  logic [rbd_pkg::SqSumW-1:0]  value_i,
  output logic                        done_o,
  output logic [rbd_pkg::RootW-1:0]   root_o,
  output logic                        rem_zero_o
);
  import rbd_pkg::*;

  localparam logic [StepW-1:0] LastStep = StepW'(RootW - 1);

  logic              busy_q, busy_d;
  logic              done_q, done_d;
  logic [StepW-1:0]  step_q, step_d;
  logic [SqSumW-1:0] val_q, val_d;
  logic [RemW-1:0]   rem_q, rem_d;
  logic [RootW-1:0]  root_q, root_d;
  logic [RemW+1:0]   shifted, trial;

  // bring down the next two bits and try root*4+1
  assign shifted = {rem_q, val_q[SqSumW-1 -: 2]};
  assign trial   = {2'b00, root_q, 2'b01};

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    step_d = step_q;
    val_d  = val_q;
    rem_d  = rem_q;
    root_d = root_q;
    if (start_i) begin
      busy_d = 1'b1;
      step_d = '0;
      val_d  = value_i;
      rem_d  = '0;
      root_d = '0;
    end else if (busy_q) begin
      val_d = {val_q[SqSumW-3:0], 2'b00};
      if (shifted >= trial) begin
        rem_d  = RemW'(shifted - trial);
        root_d = {root_q[RootW-2:0], 1'b1};
      end else begin
        rem_d  = RemW'(shifted);
        root_d = {root_q[RootW-2:0], 1'b0};
      end
      step_d = step_q + 1'b1;
      if (step_q == LastStep) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      step_q <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      step_q <= step_d;
    end
  end

  always_ff @(posedge clk_i) begin
    val_q  <= val_d;
    rem_q  <= rem_d;
    root_q <= root_d;
  end

  assign done_o     = done_q;
  assign root_o     = root_q;
  assign rem_zero_o = (rem_q == '0);

  `ASSERT_ALWAYS(a_done_after_last, clk_i, rst_ni,
    (busy_q && !start_i && step_q == LastStep) |=> (done_q && !busy_q),
    "root not flagged done after its last bit")
  `ASSERT_NEVER(a_done_while_busy, clk_i, rst_ni, done_q && busy_q,
    "root done while still iterating")

endmodule

>>> sv/rms_box_downsample_4x4_top.sv
// flow: each row item is summed one squared byte per cycle; the fourth
//   row adds a bit-serial square root per channel and then loads the output
// rows are taken only in idle, once the last one is through, a pace set by the
//   shared squarer and the shared root unit
// reset: row count, sums and the output valid flag clear at once
// ----------------------------------------------------------------------------
// rms_box_downsample_4x4_top
// 4x4 block reduction: rounded rms of the color bytes, rounded mean of alpha
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module rms_box_downsample_4x4_top (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      in_valid_i,
  output logic                      in_ready_o,
  input  logic [rbd_pkg::PixW-1:0]  pixel_a_i,
  input  logic [rbd_pkg::PixW-1:0]  pixel_b_i,
  input  logic [rbd_pkg::PixW-1:0]  pixel_c_i,
  input  logic [rbd_pkg::PixW-1:0]  pixel_d_i,
  output logic                      out_valid_o,
  input  logic                      out_ready_i,
  output logic [rbd_pkg::PixW-1:0]  out_pixel_o
);
  import rbd_pkg::*;

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_ACC  = 2'd1;
  localparam logic [1:0] ST_ROOT = 2'd2;
  localparam logic [1:0] ST_OUT  = 2'd3;

  localparam logic [ChW-1:0]     LastCh  = ChW'(NumCh - 1);
  localparam logic [PixIdxW-1:0] LastPix = PixIdxW'(PixPerRow - 1);
  localparam logic [1:0]         LastRow = 2'd3;
  localparam logic [3:0]         HalfRem = 4'd8;

  function automatic logic [ByteW-1:0] clamp_byte(input logic [ByteW:0] v);
    return v[ByteW] ? {ByteW{1'b1}} : v[ByteW-1:0];
  endfunction

  // root = 4n + t; round up when t is 3, or t is 2 and not an exact tie to even
  function automatic logic [ByteW-1:0] rms_round(input logic [RootW-1:0] root,
                                                 input logic rem_zero);
    logic [ByteW-1:0] n;
    logic             inc;
    n   = root[RootW-1:2];
    inc = root[1] & (root[0] | !rem_zero | n[0]);
    return clamp_byte({1'b0, n} + {{ByteW{1'b0}}, inc});
  endfunction

  function automatic logic [ByteW-1:0] mean_round(input logic [AlphaW-1:0] a);
    logic [ByteW-1:0] n;
    logic [3:0]       rem;
    logic             inc;
    n   = a[AlphaW-1:4];
    rem = a[3:0];
    inc = (rem > HalfRem) || ((rem == HalfRem) && n[0]);
    return clamp_byte({1'b0, n} + {{ByteW{1'b0}}, inc});
  endfunction

  function automatic logic [ByteW-1:0] chan_byte(input logic [PixW-1:0] px,
                                                 input logic [ChW-1:0] ch);
    logic [ByteW-1:0] b;
    unique case (ch)
      2'd0:    b = px[ByteW-1:0];
      2'd1:    b = px[2*ByteW-1:ByteW];
      2'd2:    b = px[3*ByteW-1:2*ByteW];
      default: b = px[4*ByteW-1:3*ByteW];
    endcase
    return b;
  endfunction

  logic [1:0]         state_q, state_d;
  logic [PixIdxW-1:0] pix_q, pix_d;
  logic [ChW-1:0]     ch_q, ch_d;
  logic [1:0]         row_q, row_d;
  logic               started_q, started_d;
  logic               out_valid_q, out_valid_d;
  logic [PixW-1:0]    out_pixel_q, out_pixel_d;
  logic [PixW-1:0]    pix_row_q [PixPerRow];
  logic [ByteW-1:0]   res_q [NumCh];
  logic [ByteW-1:0]   res_d [NumCh];

  logic               in_take;
  logic               out_load;
  logic [PixW-1:0]    pix_sel;
  rbd_acc_ctrl_t      acc_ctrl;
  logic [SqSumW-1:0]  sum_sel;
  logic [AlphaW-1:0]  alpha_sum;
  logic               sq_start;
  logic               sq_done;
  logic [RootW-1:0]   sq_root;
  logic               sq_rem_zero;

  assign in_ready_o = (state_q == ST_IDLE);
  assign in_take    = in_valid_i && in_ready_o;
  assign pix_sel    = pix_row_q[pix_q];
  assign out_load   = (state_q == ST_OUT) && (!out_valid_q || out_ready_i);
  assign sq_start   = (state_q == ST_ROOT) && !started_q;

  always_comb begin
    state_d     = state_q;
    pix_d       = pix_q;
    ch_d        = ch_q;
    row_d       = row_q;
    started_d   = started_q;
    out_valid_d = out_valid_q;
    out_pixel_d = out_pixel_q;
    for (int i = 0; i < NumCh; i++) begin
      res_d[i] = res_q[i];
    end
    acc_ctrl            = '0;
    acc_ctrl.ch         = ch_q;
    acc_ctrl.sq_byte    = chan_byte(pix_sel, ch_q);
    acc_ctrl.alpha_byte = pix_sel[PixW-1 -: ByteW];

    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end

    unique case (state_q)
      ST_IDLE: begin
        if (in_take) begin
          pix_d   = '0;
          ch_d    = '0;
          state_d = ST_ACC;
        end
      end
      ST_ACC: begin
        acc_ctrl.sq_add    = 1'b1;
        acc_ctrl.alpha_add = (ch_q == '0);
        if (ch_q == LastCh) begin
          ch_d  = '0;
          pix_d = pix_q + 1'b1;
          if (pix_q == LastPix) begin
            if (row_q == LastRow) begin
              state_d   = ST_ROOT;
              started_d = 1'b0;
            end else begin
              row_d   = row_q + 1'b1;
              state_d = ST_IDLE;
            end
          end
        end else begin
          ch_d = ch_q + 1'b1;
        end
      end
      ST_ROOT: begin
        if (sq_start) begin
          started_d = 1'b1;
        end
        if (sq_done) begin
          res_d[ch_q] = rms_round(sq_root, sq_rem_zero);
          started_d   = 1'b0;
          if (ch_q == LastCh) begin
            ch_d    = '0;
            state_d = ST_OUT;
          end else begin
            ch_d = ch_q + 1'b1;
          end
        end
      end
      ST_OUT: begin
        if (out_load) begin
          out_valid_d    = 1'b1;
          out_pixel_d    = {mean_round(alpha_sum), res_q[2], res_q[1], res_q[0]};
          acc_ctrl.clear = 1'b1;
          row_d          = '0;
          state_d        = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      pix_q       <= '0;
      ch_q        <= '0;
      row_q       <= '0;
      started_q   <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      pix_q       <= pix_d;
      ch_q        <= ch_d;
      row_q       <= row_d;
      started_q   <= started_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_pixel_q <= out_pixel_d;
    for (int i = 0; i < NumCh; i++) begin
      res_q[i] <= res_d[i];
    end
    if (in_take) begin
      pix_row_q[0] <= pixel_a_i;
      pix_row_q[1] <= pixel_b_i;
      pix_row_q[2] <= pixel_c_i;
      pix_row_q[3] <= pixel_d_i;
    end
  end

  rbd_accum u_accum (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .ctrl_i  (acc_ctrl),
    .sel_i   (ch_q),
    .sum_o   (sum_sel),
    .alpha_o (alpha_sum)
  );

  rbd_isqrt u_isqrt (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (sq_start),
    .value_i    (sum_sel),
    .done_o     (sq_done),
    .root_o     (sq_root),
    .rem_zero_o (sq_rem_zero)
  );

  assign out_valid_o = out_valid_q;
  assign out_pixel_o = out_pixel_q;

  `ASSERT_ALWAYS(a_take_starts_acc, clk_i, rst_ni, in_take |=> (state_q == ST_ACC),
    "accepted row item did not start accumulation")
  `ASSERT_NEVER(a_done_outside_root, clk_i, rst_ni, sq_done && (state_q != ST_ROOT),
    "square root finished outside the root phase")
  `ASSERT_ALWAYS(a_load_frees_slot, clk_i, rst_ni,
    out_load |-> (!out_valid_q || out_ready_i),
    "output overwritten while a result still waits")
  `ASSERT_ALWAYS(a_root_only_last_row, clk_i, rst_ni,
    (state_q == ST_ACC && state_d == ST_ROOT) |-> (row_q == LastRow),
    "root phase entered before the fourth row")

endmodule

>>> tb/rms_box_downsample_4x4_top_test.sv
// ----------------------------------------------------------------------------
// rms_box_downsample_4x4_top_test
// drives 4x4 pixel blocks row by row into the downsampler, predicts each
// resolved pixel (rounded rms of the color bytes, rounded mean of alpha) and
// compares every output item against the oldest predicted pixel in order
// ----------------------------------------------------------------------------
module rms_box_downsample_4x4_top_test;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned PixW = rbd_pkg::PixW;
  localparam int unsigned RowsPerBlock = 4;
  localparam int unsigned TargetRows = 850;
  localparam int unsigned LongHoldCycles = 600;
  localparam int unsigned DrainCycles = 100;

  // running sums of one block and the queue of resolved pixels still owed
  class box_pixel_board;
    bit [1:0]      rows_seen;
    bit [19:0]     sq_sum [3];
    bit [11:0]     alpha_acc;
    bit [31:0]     pending_pixels [$];
    int unsigned   mismatches;
    int unsigned   pixels_matched;
    int unsigned   rows_taken;

    function bit [7:0] rounded_rms(bit [19:0] s);
      bit [10:0] root;
      bit [10:0] trial;
      bit [31:0] n;
      bit [31:0] half;
      root = '0;
      for (int i = 10; i >= 0; i--) begin
        trial = root | (11'd1 << i);
        if (32'(trial) * 32'(trial) <= 32'(s)) root = trial;
      end
      n = 32'(root >> 2);
      // (4n+2)^2 is the exact half point between n and n+1
      half = 16 * n * n + 16 * n + 4;
      if (32'(s) > half || (32'(s) == half && n[0])) n++;
      if (n > 255) n = 255;
      return n[7:0];
    endfunction

    function bit [7:0] rounded_mean(bit [11:0] a);
      bit [31:0] n;
      bit [3:0]  rem;
      n = 32'(a >> 4);
      rem = a[3:0];
      if (rem > 4'd8 || (rem == 4'd8 && n[0])) n++;
      if (n > 255) n = 255;
      return n[7:0];
    endfunction

    function void take_row(bit [31:0] pa, bit [31:0] pb, bit [31:0] pc, bit [31:0] pd);
      bit [31:0] px [4];
      bit [31:0] resolved;
      bit [7:0]  b;
      px[0] = pa;
      px[1] = pb;
      px[2] = pc;
      px[3] = pd;
      rows_taken++;
      for (int p = 0; p < 4; p++) begin
        for (int c = 0; c < 3; c++) begin
          b = px[p][8*c +: 8];
          sq_sum[c] = sq_sum[c] + 20'(16'(b) * 16'(b));
        end
        alpha_acc = alpha_acc + 12'(px[p][31:24]);
      end
      if (rows_seen != 2'd3) begin
        rows_seen++;
      end else begin
        for (int c = 0; c < 3; c++) resolved[8*c +: 8] = rounded_rms(sq_sum[c]);
        resolved[31:24] = rounded_mean(alpha_acc);
        pending_pixels.push_back(resolved);
        rows_seen = '0;
        for (int c = 0; c < 3; c++) sq_sum[c] = '0;
        alpha_acc = '0;
      end
    endfunction

    function void match_pixel(bit [31:0] got);
      bit [31:0] want;
      if (pending_pixels.size() == 0) begin
        $display("%0t: unexpected out_pixel %08h with no block pending", $time, got);
        mismatches++;
      end else begin
        want = pending_pixels.pop_front();
        if (got !== want) begin
          $display("%0t: out_pixel mismatch, expected %08h, actual %08h", $time, want, got);
          mismatches++;
        end else begin
          pixels_matched++;
        end
      end
    endfunction

    function int unsigned waiting();
      return pending_pixels.size();
    endfunction
  endclass

  logic            clk_i = 1'b0;
  logic            rst_ni = 1'b0;
  logic            in_valid = 1'b0;
  logic            in_ready;
  logic [PixW-1:0] pixel_a = '0;
  logic [PixW-1:0] pixel_b = '0;
  logic [PixW-1:0] pixel_c = '0;
  logic [PixW-1:0] pixel_d = '0;
  logic            out_valid;
  logic            out_ready = 1'b0;
  logic [PixW-1:0] out_pixel;

  box_pixel_board board = new();

  logic [31:0] block_px [16];
  int unsigned blocks_sent = 0;
  int unsigned burst_left = 0;
  bit          no_gaps = 1'b0;
  int unsigned hold_trigger = 0;

  always #5 clk_i = ~clk_i;

  rms_box_downsample_4x4_top u_top (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready),
    .pixel_a_i   (pixel_a),
    .pixel_b_i   (pixel_b),
    .pixel_c_i   (pixel_c),
    .pixel_d_i   (pixel_d),
    .out_valid_o (out_valid),
    .out_ready_i (out_ready),
    .out_pixel_o (out_pixel)
  );

  // receiver: checks accepted pixels and stalls on a pattern of its own
  int unsigned rx_phase = 0;
  int unsigned rx_mode = 0;
  int unsigned hold_seen = 0;
  int unsigned hold_left = 0;

  always @(posedge clk_i) begin
    if (rst_ni && out_valid && out_ready) board.match_pixel(out_pixel);
    if (hold_trigger != hold_seen) begin
      hold_seen = hold_trigger;
      hold_left = LongHoldCycles;
    end
    if (hold_left != 0) begin
      hold_left--;
      out_ready <= 1'b0;
    end else begin
      case (rx_mode)
        0: out_ready <= 1'b1;
        1: out_ready <= 1'($urandom_range(0, 1));
        2: out_ready <= (rx_phase % 5) != 0;
        default: out_ready <= ($urandom_range(0, 7) == 0);
      endcase
    end
    rx_phase++;
    if (rx_phase % 257 == 0) rx_mode = no_gaps ? 0 : $urandom_range(0, 3);
  end

  // hold the row until it is taken, then apply the sender's burst and gap pattern
  task automatic send_row(input logic [31:0] pa, input logic [31:0] pb,
                          input logic [31:0] pc, input logic [31:0] pd);
    int unsigned gap;
    in_valid <= 1'b1;
    pixel_a <= pa;
    pixel_b <= pb;
    pixel_c <= pc;
    pixel_d <= pd;
    @(posedge clk_i);
    while (!in_ready) @(posedge clk_i);
    board.take_row(pa, pb, pc, pd);
    if (!no_gaps) begin
      if (burst_left == 0) begin
        burst_left = $urandom_range(1, 16);
        gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 20);
        if (gap != 0) begin
          in_valid <= 1'b0;
          repeat (gap) @(posedge clk_i);
        end
      end else begin
        burst_left--;
      end
    end
  endtask

  task automatic send_block();
    for (int r = 0; r < RowsPerBlock; r++)
      send_row(block_px[4*r], block_px[4*r+1], block_px[4*r+2], block_px[4*r+3]);
    blocks_sent++;
  endtask

  function automatic logic [7:0] pick_byte(int unsigned kind);
    case (kind)
      1: return 8'($urandom_range(0, 15));
      2: return $urandom_range(0, 1) ? 8'hff : 8'h00;
      default: return 8'($urandom);
    endcase
  endfunction

  // fill block_px with one random block of the given kind
  task automatic make_block(input int unsigned kind);
    logic [31:0] same;
    int unsigned pos;
    if (kind == 3) begin
      // one nonzero byte per channel landing exactly on a rounding half
      for (int i = 0; i < 16; i++) block_px[i] = '0;
      for (int c = 0; c < 3; c++) begin
        pos = $urandom_range(0, 15);
        block_px[pos][8*c +: 8] = 8'(4 * $urandom_range(0, 63) + 2);
      end
      pos = $urandom_range(0, 15);
      block_px[pos][31:24] = 8'(16 * $urandom_range(0, 15) + 8);
    end else if (kind == 4) begin
      same = $urandom;
      for (int i = 0; i < 16; i++) block_px[i] = same;
    end else begin
      for (int i = 0; i < 16; i++)
        for (int c = 0; c < 4; c++) block_px[i][8*c +: 8] = pick_byte(kind);
    end
  endtask

  task automatic wait_drained();
    while (board.waiting() != 0) @(posedge clk_i);
  endtask

  initial begin
    int unsigned kind;
    int unsigned roll;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // all zero block
    for (int i = 0; i < 16; i++) block_px[i] = 32'h0000_0000;
    send_block();
    // all ones: largest channel and alpha sums
    for (int i = 0; i < 16; i++) block_px[i] = 32'hffff_ffff;
    send_block();
    // exact half rounds down to the even 0 in rms and alpha
    for (int i = 0; i < 16; i++) block_px[i] = '0;
    block_px[0] = 32'h0802_0202;
    send_block();
    // exact half rounds up to the even 2 in rms and alpha
    block_px[0] = 32'h1806_0606;
    send_block();
    // just past the half point rounds up
    block_px[0] = 32'h0902_0202;
    block_px[5] = 32'h0001_0101;
    send_block();

    while (board.rows_taken < TargetRows) begin
      if (blocks_sent == 50) begin
        // receiver holds off while rows keep coming back to back
        hold_trigger++;
        no_gaps = 1'b1;
      end else if (blocks_sent == 60) begin
        no_gaps = 1'b0;
      end else if (blocks_sent == 100) begin
        in_valid <= 1'b0;
        wait_drained();
      end else if (blocks_sent == 140) begin
        no_gaps = 1'b1;
      end else if (blocks_sent == 170) begin
        no_gaps = 1'b0;
      end
      roll = $urandom_range(0, 9);
      kind = (roll < 4) ? 0 : (roll < 6) ? 1 : (roll < 7) ? 2 : (roll < 9) ? 3 : 4;
      make_block(kind);
      send_block();
    end

    // a trailing partial block that owes no pixel
    make_block(0);
    send_row(block_px[0], block_px[1], block_px[2], block_px[3]);
    send_row(block_px[4], block_px[5], block_px[6], block_px[7]);
    in_valid <= 1'b0;

    wait_drained();
    repeat (DrainCycles) @(posedge clk_i);

    $display("sent %0d rows in %0d full blocks plus a partial one, %0d pixels matched",
             board.rows_taken, blocks_sent, board.pixels_matched);
    $display("covered zero, full scale, tie-to-even, uniform and random blocks under stalls");
    if (board.mismatches == 0 && board.waiting() == 0) begin
      $display("PASS rms_box_downsample_4x4_top");
    end else begin
      $display("FAIL rms_box_downsample_4x4_top");
    end
    $finish;
  end

  initial begin
    #5ms;
    $display("%0t: timeout with %0d pixels still pending", $time, board.waiting());
    $display("FAIL rms_box_downsample_4x4_top");
    $finish;
  end

endmodule

>>> filelist.f
+incdir+sv
sv/rbd_pkg.sv
sv/rbd_accum.sv
sv/rbd_isqrt.sv
sv/rms_box_downsample_4x4_top.sv
tb/rms_box_downsample_4x4_top_test.sv
